// ===== src/zvm_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the zone volume controller.
package zvm_pkg;

   localparam int NUM_ZONES_DEFAULT = 4;

   localparam int MODE_W  = 3;
   localparam int ZONE_W  = 3;
   localparam int LEVEL_W = 9;
   localparam int WIRE_W  = 8;
   localparam int PCT_W   = 7;
   localparam int STEP_W  = 5;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   localparam logic [MODE_W-1:0] MODE_SET_ZONE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET_MASTER  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_NUDGE       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TOGGLE_ZONE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TOGGLE_ALL  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REPORT      = 3'd5;

   typedef logic [1:0] lvl_sel_type;
   localparam lvl_sel_type LW_NONE   = 2'd0;
   localparam lvl_sel_type LW_SET    = 2'd1;
   localparam lvl_sel_type LW_REPORT = 2'd2;
   localparam lvl_sel_type LW_MASTER = 2'd3;

   typedef struct packed {
      logic        capture;
      logic        idx_zero;
      logic        idx_load_zone;
      logic        idx_inc;
      logic        scan_step;
      logic        v_load;
      logic        div_start;
      lvl_sel_type lvl_sel;
      logic        mute_clear;
      logic        mute_toggle;
      logic        mute_all;
      logic        out_load;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              zone_ok;
      logic              link;
      logic              idx_last;
      logic              old_zero;
      logic              div_busy;
      logic              out_free;
   } sts_type;

endpackage

// ===== src/zvm_ctrl.sv =====
// Command sequencer for the zone volume controller.
module zvm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  zvm_pkg::sts_type sts,
   output zvm_pkg::cmd_type cmd
);
   import zvm_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_DISPATCH = 3'd2;
   localparam logic [2:0] ST_APPLY    = 3'd3;
   localparam logic [2:0] ST_EMIT_ONE = 3'd4;
   localparam logic [2:0] ST_MASTER   = 3'd5;
   localparam logic [2:0] ST_DIVIDE   = 3'd6;
   localparam logic [2:0] ST_EMIT_ALL = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_DISPATCH;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_DISPATCH: begin
            priority if (sts.mode == MODE_SET_ZONE || sts.mode == MODE_TOGGLE_ZONE ||
                         sts.mode == MODE_REPORT) begin
               if (sts.zone_ok) begin
                  cmd.idx_load_zone = 1'b1;
                  state_in          = ST_APPLY;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (sts.mode == MODE_SET_MASTER || sts.mode == MODE_NUDGE) begin
               cmd.v_load   = 1'b1;
               cmd.idx_zero = 1'b1;
               state_in     = ST_MASTER;
            end else if (sts.mode == MODE_TOGGLE_ALL) begin
               cmd.mute_all = 1'b1;
               cmd.idx_zero = 1'b1;
               state_in     = sts.link ? ST_EMIT_ALL : ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_APPLY: begin
            unique case (sts.mode)
               MODE_SET_ZONE: begin
                  cmd.lvl_sel    = LW_SET;
                  cmd.mute_clear = 1'b1;
                  state_in       = sts.link ? ST_EMIT_ONE : ST_IDLE;
               end
               MODE_TOGGLE_ZONE: begin
                  cmd.mute_toggle = 1'b1;
                  state_in        = sts.link ? ST_EMIT_ONE : ST_IDLE;
               end
               MODE_REPORT: begin
                  cmd.lvl_sel = LW_REPORT;
                  state_in    = ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT_ONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MASTER, ST_DIVIDE: begin
            if (state_ff == ST_MASTER && !sts.old_zero) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else if (!sts.div_busy) begin
               cmd.lvl_sel = LW_MASTER;
               if (sts.idx_last) begin
                  cmd.idx_zero = 1'b1;
                  state_in     = sts.link ? ST_EMIT_ALL : ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_MASTER;
               end
            end
         end
         ST_EMIT_ALL: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = sts.idx_last;
               if (sts.idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/zvm_dp.sv =====
// Zone state, rescale divider and output register for the zone volume controller.
module zvm_dp #(
   parameter int NUM_ZONES = zvm_pkg::NUM_ZONES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic                                csr_write_data,
   input  logic [zvm_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [zvm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   input  zvm_pkg::cmd_type                    cmd,
   output zvm_pkg::sts_type                    sts
);
   import zvm_pkg::*;

   localparam int ZI_W  = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
   localparam int NUM_W = 15;
   localparam int DEN_W = 8;

   function automatic logic [STEP_W-1:0] pct_to_wire(input logic [PCT_W-1:0] pct);
      logic [20:0] prod;
      prod = 21'(pct) * 21'd15732;
      return prod[20:16];
   endfunction

   logic                     link_ff;
   logic [MODE_W-1:0]        mode_ff;
   logic [ZONE_W-1:0]        zone_ff;
   logic signed [LEVEL_W-1:0] level_ff;
   logic [WIRE_W-1:0]        wire_ff;
   logic [ZI_W-1:0]          idx_ff;
   logic [ZI_W-1:0]          idx_in;
   logic [PCT_W-1:0]         max_ff;
   logic [PCT_W-1:0]         v_ff;
   logic [PCT_W-1:0]         lvl_ff [NUM_ZONES];
   logic [NUM_ZONES-1:0]     muted_ff;

   logic [NUM_W-1:0]         quo_ff;
   logic [DEN_W-1:0]         rem_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [3:0]               cnt_ff;
   logic                     run_ff;

   logic                     rsp_valid_ff;
   logic [ZONE_W-1:0]        rsp_zone_ff;
   logic [STEP_W-1:0]        rsp_wire_ff;
   logic                     rsp_last_ff;

   logic [PCT_W-1:0]         lvl_rd;
   logic                     muted_rd;
   logic [PCT_W-1:0]         set_clamp;
   logic [PCT_W-1:0]         report_pct;
   logic [23:0]              report_prod;
   logic signed [LEVEL_W:0]  v_sum;
   logic [PCT_W-1:0]         v_clamp;
   logic [13:0]              mult;
   logic [NUM_W-1:0]         num;
   logic [DEN_W:0]           shifted;
   logic [DEN_W:0]           trial;
   logic [PCT_W-1:0]         quo_clamp;
   logic [PCT_W-1:0]         lvl_wdata;
   logic                     out_free;

   assign lvl_rd   = lvl_ff[idx_ff];
   assign muted_rd = muted_ff[idx_ff];

   always_comb begin
      if (level_ff < 0) begin
         set_clamp = '0;
      end else if (level_ff > $signed({2'b00, PCT_MAX})) begin
         set_clamp = PCT_MAX;
      end else begin
         set_clamp = level_ff[PCT_W-1:0];
      end
   end

   assign report_prod = 24'(wire_ff[4:0]) * 24'd273075;
   assign report_pct  = (wire_ff >= 8'd24) ? PCT_MAX : report_prod[22:16];

   always_comb begin
      if (mode_ff == MODE_NUDGE) begin
         v_sum = $signed({3'b000, max_ff}) + $signed({level_ff[LEVEL_W-1], level_ff});
      end else begin
         v_sum = $signed({level_ff[LEVEL_W-1], level_ff});
      end
      if (v_sum < 0) begin
         v_clamp = '0;
      end else if (v_sum > $signed({3'b000, PCT_MAX})) begin
         v_clamp = PCT_MAX;
      end else begin
         v_clamp = v_sum[PCT_W-1:0];
      end
   end

   assign mult    = 14'(lvl_rd) * 14'(v_ff);
   assign num     = {mult, 1'b0} + NUM_W'(max_ff);
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   assign quo_clamp = (quo_ff > NUM_W'(PCT_MAX)) ? PCT_MAX : quo_ff[PCT_W-1:0];

   always_comb begin
      unique case (cmd.lvl_sel)
         LW_SET:    lvl_wdata = set_clamp;
         LW_REPORT: lvl_wdata = report_pct;
         LW_MASTER: lvl_wdata = (max_ff == '0) ? v_ff : quo_clamp;
         default:   lvl_wdata = lvl_rd;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      priority if (cmd.capture || cmd.idx_zero) begin
         idx_in = '0;
      end else if (cmd.idx_load_zone) begin
         idx_in = zone_ff[ZI_W-1:0];
      end else if (cmd.idx_inc) begin
         idx_in = ZI_W'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff  <= 1'b0;
         idx_ff   <= '0;
         max_ff   <= '0;
         muted_ff <= '0;
         run_ff   <= 1'b0;
         for (int i = 0; i < NUM_ZONES; i++) begin
            lvl_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            link_ff <= csr_write_data;
         end
         idx_ff <= idx_in;
         if (cmd.capture) begin
            max_ff <= '0;
         end else if (cmd.scan_step && lvl_rd > max_ff) begin
            max_ff <= lvl_rd;
         end
         if (cmd.lvl_sel != LW_NONE) begin
            lvl_ff[idx_ff] <= lvl_wdata;
         end
         priority if (cmd.mute_all) begin
            muted_ff <= {NUM_ZONES{~(|muted_ff)}};
         end else if (cmd.mute_clear) begin
            muted_ff[idx_ff] <= 1'b0;
         end else if (cmd.mute_toggle) begin
            muted_ff[idx_ff] <= ~muted_rd;
         end
         if (cmd.div_start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == 4'd1) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_tdata[2:0];
         zone_ff  <= req_tdata[5:3];
         level_ff <= req_tdata[14:6];
         wire_ff  <= req_tdata[22:15];
      end
      if (cmd.v_load) begin
         v_ff <= v_clamp;
      end
      if (cmd.div_start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= {max_ff, 1'b0};
         cnt_ff <= 4'(NUM_W);
      end else if (run_ff) begin
         cnt_ff <= cnt_ff - 4'd1;
         if (!trial[DEN_W]) begin
            rem_ff <= trial[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DEN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_zone_ff <= ZONE_W'(idx_ff);
         rsp_wire_ff <= muted_rd ? '0 : pct_to_wire(lvl_rd);
         rsp_last_ff <= cmd.out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_wire_ff, rsp_zone_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign sts.mode     = mode_ff;
   assign sts.zone_ok  = {1'b0, zone_ff} < 4'(NUM_ZONES);
   assign sts.link     = link_ff;
   assign sts.idx_last = (idx_ff == ZI_W'(NUM_ZONES - 1));
   assign sts.old_zero = (max_ff == '0);
   assign sts.div_busy = run_ff;
   assign sts.out_free = out_free;

endmodule

// ===== src/zone_volume_mute_controller_core.sv =====
// Top level of the zone volume and mute controller.
//
// Commands enter on the req_ stream, one transaction per command; volume
// commands leave on the rsp_ stream, one transaction per zone addressed,
// with rsp_tlast on the final one of a command. csr_write_enable with
// csr_write_data sets the link enable bit; while it is clear, state still
// updates but nothing is sent.
// The block takes one command at a time: req_tready is high only while idle.
// Every command first scans the zones for the loudest level. Zone commands
// then update the addressed zone and, but for report, emit it. Toggle all
// unmutes every zone if any is muted, else mutes them all, and emits every
// zone. Set and nudge master run one restoring divide per zone, unless the
// loudest level is zero; the divider is shared by all zones, and no new
// command is taken until the last zone is written back.
// Reset clears all levels to 0, unmutes all zones and clears link enable.
// A stalled receiver holds the output register; the sequencer waits for it.
module zone_volume_mute_controller_core #(
   parameter int NUM_ZONES = zvm_pkg::NUM_ZONES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic                           csr_write_data,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode[2:0], zone[5:3], level[14:6], wire_level[22:15], zero[23]
   input  logic [zvm_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_zone[2:0], out_wire_level[7:3]
   output logic [zvm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import zvm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   zvm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   zvm_dp #(
      .NUM_ZONES (NUM_ZONES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the zone volume and mute controller core.
module testbench;
   import zvm_pkg::*;

   localparam int ZONES          = NUM_ZONES_DEFAULT;
   localparam int ZONE_IDX_W     = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int STEP_MAX       = 24;
   localparam int SETTLE_CYCLES  = 160;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

   typedef struct packed {
      logic [ZONE_W-1:0] zone;
      logic [STEP_W-1:0] steps;
      logic              last;
   } volume_cmd_type;

   class zone_volume_book;
      logic [PCT_W-1:0] level_pct [ZONES];
      bit               muted [ZONES];
      bit               link_on;
      volume_cmd_type   pending_cmds[$];
      int               errors;

      function new();
         for (int i = 0; i < ZONES; i++) begin
            level_pct[i] = '0;
            muted[i]     = 1'b0;
         end
         link_on = 1'b0;
         errors  = 0;
      endfunction

      function int clamp_pct(int v);
         return (v < 0) ? 0 : ((v > int'(PCT_MAX)) ? int'(PCT_MAX) : v);
      endfunction

      function int loudest();
         int m;
         m = 0;
         for (int i = 0; i < ZONES; i++)
            if (int'(level_pct[i]) > m) m = int'(level_pct[i]);
         return m;
      endfunction

      function void push_cmd(int z, int pct, bit last);
         volume_cmd_type c;
         int             s;
         s = pct * STEP_MAX / int'(PCT_MAX);
         if (s > STEP_MAX) s = STEP_MAX;
         c.zone  = z[ZONE_W-1:0];
         c.steps = s[STEP_W-1:0];
         c.last  = last;
         pending_cmds.push_back(c);
      endfunction

      function void emit_all();
         if (!link_on) return;
         for (int i = 0; i < ZONES; i++)
            push_cmd(i, muted[i] ? 0 : int'(level_pct[i]), i == ZONES - 1);
      endfunction

      function void rescale(int req);
         int v;
         int old;
         int nv;
         v   = clamp_pct(req);
         old = loudest();
         for (int i = 0; i < ZONES; i++) begin
            if (old == 0) begin
               nv = v;
            end else begin
               nv = (2 * int'(level_pct[i]) * v + old) / (2 * old);
               if (nv > int'(PCT_MAX)) nv = int'(PCT_MAX);
            end
            level_pct[i] = nv[PCT_W-1:0];
         end
         emit_all();
      endfunction

      function void note_command(logic [MODE_W-1:0] mode, logic [ZONE_W-1:0] zone,
                                 int level, int wire_lvl);
         bit                    zone_ok;
         bit                    any;
         int                    p;
         logic [ZONE_IDX_W-1:0] zi;
         zone_ok = int'(zone) < ZONES;
         zi      = zone[ZONE_IDX_W-1:0];
         case (mode)
            MODE_SET_ZONE: begin
               if (!zone_ok) return;
               level_pct[zi] = PCT_W'(clamp_pct(level));
               muted[zi]     = 1'b0;
               if (link_on) push_cmd(int'(zone), int'(level_pct[zi]), 1'b1);
            end
            MODE_SET_MASTER: rescale(level);
            MODE_NUDGE:      rescale(loudest() + level);
            MODE_TOGGLE_ZONE: begin
               if (!zone_ok) return;
               muted[zi] = !muted[zi];
               if (link_on) push_cmd(int'(zone), muted[zi] ? 0 : int'(level_pct[zi]), 1'b1);
            end
            MODE_TOGGLE_ALL: begin
               any = 1'b0;
               for (int i = 0; i < ZONES; i++)
                  if (muted[i]) any = 1'b1;
               for (int i = 0; i < ZONES; i++) muted[i] = !any;
               emit_all();
            end
            MODE_REPORT: begin
               if (!zone_ok) return;
               p = (wire_lvl & 8'hFF) * int'(PCT_MAX) / STEP_MAX;
               level_pct[zi] = PCT_W'(clamp_pct(p));
            end
            default: ;
         endcase
      endfunction

      function void check_volume_cmd(logic [ZONE_W-1:0] zone, logic [STEP_W-1:0] steps,
                                     logic last);
         volume_cmd_type exp_cmd;
         if (pending_cmds.size() == 0) begin
            $error("unexpected volume command: zone %0d steps %0d last %0b", zone, steps, last);
            errors++;
            return;
         end
         exp_cmd = pending_cmds.pop_front();
         if (zone !== exp_cmd.zone) begin
            $error("out_zone: expected %0d, actual %0d", exp_cmd.zone, zone);
            errors++;
         end
         if (steps !== exp_cmd.steps) begin
            $error("out_wire_level: expected %0d, actual %0d", exp_cmd.steps, steps);
            errors++;
         end
         if (last !== exp_cmd.last) begin
            $error("last: expected %0b, actual %0b", exp_cmd.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_write_data   = 1'b0;
   logic                  req_tvalid       = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata        = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready       = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   zone_volume_book book;
   bit              gaps_on      = 1'b1;
   bit              rx_stalls_on = 1'b1;
   int              stall_left   = 0;
   int              quiet_cycles = 0;

   zone_volume_mute_controller_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rx_stalls_on && $urandom_range(7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(14, 1) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_volume_cmd(rsp_tdata[2:0], rsp_tdata[7:3], rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_link(bit on);
      csr_write_enable <= 1'b1;
      csr_write_data   <= on;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      book.link_on = on;
   endtask

   task automatic send_command(logic [MODE_W-1:0] mode, logic [ZONE_W-1:0] zone,
                               int level, int wire_lvl);
      logic [LEVEL_W-1:0] lvl9;
      logic [WIRE_W-1:0]  wire8;
      lvl9  = LEVEL_W'(level);
      wire8 = WIRE_W'(wire_lvl);
      if (gaps_on && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, wire8, lvl9, zone, mode};
      do @(posedge clock); while (!req_tready);
      book.note_command(mode, zone, level, wire_lvl);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.pending_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count, int pause_at);
      logic [MODE_W-1:0] mode;
      logic [ZONE_W-1:0] zone;
      int                level;
      int                wire_lvl;
      int                r;
      int                done;
      bit                ignored;
      done = 0;
      while (done < count) begin
         r = $urandom_range(99);
         if (r < 22)      mode = MODE_SET_ZONE;
         else if (r < 34) mode = MODE_SET_MASTER;
         else if (r < 46) mode = MODE_NUDGE;
         else if (r < 62) mode = MODE_TOGGLE_ZONE;
         else if (r < 72) mode = MODE_TOGGLE_ALL;
         else if (r < 92) mode = MODE_REPORT;
         else             mode = ($urandom_range(1) == 0) ? MODE_SPARE_A : MODE_SPARE_B;
         zone = ZONE_W'(($urandom_range(99) < 85) ? $urandom_range(ZONES - 1)
                                                  : $urandom_range(7, ZONES));
         r = $urandom_range(99);
         if (mode == MODE_NUDGE)
            level = (r < 60) ? int'($urandom_range(40)) - 20 : int'($urandom_range(510)) - 255;
         else if (r < 70)
            level = $urandom_range(100);
         else if (r < 85)
            level = ($urandom_range(1) == 0) ? -255 : 255;
         else
            level = int'($urandom_range(510)) - 255;
         wire_lvl = ($urandom_range(1) == 0) ? $urandom_range(STEP_MAX) : $urandom_range(255);
         send_command(mode, zone, level, wire_lvl);
         ignored = (mode == MODE_SPARE_A) || (mode == MODE_SPARE_B) ||
                   ((mode == MODE_SET_ZONE || mode == MODE_TOGGLE_ZONE ||
                     mode == MODE_REPORT) && int'(zone) >= ZONES);
         if (!ignored) begin
            done++;
            if (done == pause_at) hold_until_drained();
         end
      end
   endtask

   initial begin
      book = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_link(1'b1);

      send_command(MODE_SET_MASTER, 0, 50, 0);
      send_command(MODE_SET_ZONE, 0, 100, 0);
      send_command(MODE_SET_ZONE, 1, -255, 0);
      send_command(MODE_SET_ZONE, 2, 255, 0);
      send_command(MODE_SET_ZONE, 3, 37, 0);
      send_command(MODE_SET_MASTER, 0, 33, 0);
      send_command(MODE_NUDGE, 0, 255, 0);
      send_command(MODE_NUDGE, 0, -255, 0);
      send_command(MODE_NUDGE, 0, 7, 0);
      send_command(MODE_SET_ZONE, 1, 100, 0);
      send_command(MODE_SET_MASTER, 0, 50, 0);
      send_command(MODE_TOGGLE_ZONE, 2, 0, 0);
      send_command(MODE_TOGGLE_ALL, 0, 0, 0);
      send_command(MODE_TOGGLE_ALL, 0, 0, 0);
      send_command(MODE_TOGGLE_ZONE, 0, 0, 0);
      send_command(MODE_REPORT, 1, 0, 255);
      send_command(MODE_REPORT, 2, 0, 0);
      send_command(MODE_REPORT, 3, 0, 25);
      send_command(MODE_REPORT, 0, 0, 13);
      send_command(MODE_SET_ZONE, 4, 60, 0);
      send_command(MODE_TOGGLE_ZONE, 7, 0, 0);
      send_command(MODE_REPORT, 5, 0, 255);
      send_command(MODE_SPARE_A, 1, 255, 255);
      send_command(MODE_SPARE_B, 6, -1, 128);
      send_command(MODE_TOGGLE_ALL, 0, 0, 0);
      send_command(MODE_SET_MASTER, 0, 0, 0);
      send_command(MODE_SET_MASTER, 0, 255, 0);
      settle();

      run_random(80, 40);
      settle();
      write_link(1'b0);
      run_random(35, 0);
      settle();
      write_link(1'b1);
      run_random(40, 20);
      gaps_on      = 1'b0;
      rx_stalls_on = 1'b0;
      run_random(30, 0);
      settle();

      book.errors += book.pending_cmds.size();
      if (book.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
